// ----- hw/rtl/weighted_bilinear_table_interp_top_defines.svh -----
// Assertion macros for the weighted bilinear table interpolator.
// Used by the top-level module only.
`ifndef WEIGHTED_BILINEAR_TABLE_INTERP_TOP_DEFINES_SVH
`define WEIGHTED_BILINEAR_TABLE_INTERP_TOP_DEFINES_SVH

// Implication checked on every edge outside reset
`define WBTI_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked in the cycle after the antecedent
`define WBTI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/wbti_pkg.sv -----
// Shared types and constants for the weighted bilinear table interpolator.
// No dependencies.
package wbti_pkg;
    localparam int ROWS         = 512;
    localparam int ENERGY_KNOTS = 16;
    localparam int COSINE_KNOTS = 32;
    localparam int ROW_W = 9;
    localparam int ES_W  = 4;
    localparam int CS_W  = 5;
    localparam int GRID_AW = ROW_W + ES_W + CS_W;

    typedef enum logic [1:0] {
        OP_GRID   = 2'd0,
        OP_ENERGY = 2'd1,
        OP_COSINE = 2'd2,
        OP_QUERY  = 2'd3
    } op_t;

    localparam logic CFG_ENERGY_USED = 1'b0;
    localparam logic CFG_COSINE_USED = 1'b1;

    localparam logic [4:0] ENERGY_USED_RST = 5'd10;
    localparam logic [5:0] COSINE_USED_RST = 6'd25;

    localparam logic signed [47:0] SUM_MAX = {1'b0, {47{1'b1}}};
    localparam logic signed [47:0] SUM_MIN = {1'b1, {47{1'b0}}};
endpackage

// ----- hw/rtl/wbti_divider.sv -----
// Restoring divider: 24-bit unsigned quotient of (num << 24) / den, num < den.
// Depends on nothing; one quotient bit per cycle.
module wbti_divider (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [32:0] num,
    input  logic [32:0] den,
    output logic        done,
    output logic [23:0] quot
);
    logic [33:0] rem_reg, rem_next;
    logic [32:0] den_reg;
    logic [23:0] q_reg, q_next;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic [34:0] trial;

    // one shift-subtract step
    always_comb begin
        trial    = {rem_reg, 1'b0} - {2'b00, den_reg};
        rem_next = {rem_reg[32:0], 1'b0};
        q_next   = {q_reg[22:0], 1'b0};
        if (!trial[34]) begin
            rem_next = trial[33:0];
            q_next   = {q_reg[22:0], 1'b1};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done     <= 1'b0;
        end else begin
            done <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'd0;
                rem_reg  <= {1'b0, num};
                den_reg  <= den;
                q_reg    <= '0;
            end else if (busy_reg) begin
                rem_reg <= rem_next;
                q_reg   <= q_next;
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd23) begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end
    assign quot = q_reg;
endmodule

// ----- hw/rtl/weighted_bilinear_table_interp_top.sv -----
// Top level of the weighted bilinear table interpolator.
// Depends on wbti_pkg, wbti_divider and weighted_bilinear_table_interp_top_defines.svh.
//
// Usage:
//  Input channel s_*: one item per handshake. op selects grid write, energy knot
//  write, cosine knot write or query. A write passes through the write state and
//  returns to idle. For each axis in turn a query runs a binary search (each probe
//  a registered axis read, then a compare), then a 24-step division for the
//  fraction (skipped when the fraction is 0 or 1); it then reads four grid words
//  from the grid memory and pushes six products through a single 33x33 signed
//  multiplier. The block takes no new item until a query is done and it is back
//  in idle.
//  Output channel m_*: a result item appears only for a query with last set,
//  carrying the saturated Q24.24 sum, the row and the clip flag. The sum is
//  cleared when the result is produced.
//  s_ready is high whenever the sequencer is idle. A result waiting for the
//  receiver holds only a later query that ends a run, just before its output.
//  Reset clears the sum, clip flag and control and sets the knot counts (10, 25).
//  Tables are undefined until written; no clearing pass.
//  Configuration: cfg_we, cfg_index, cfg_data; index 0 energy count, 1 cosine.
`include "weighted_bilinear_table_interp_top_defines.svh"
module weighted_bilinear_table_interp_top (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [5:0]         cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_op,
    input  logic [8:0]         s_row,
    input  logic [3:0]         s_energy_slot,
    input  logic [4:0]         s_cosine_slot,
    input  logic signed [31:0] s_write_value,
    input  logic signed [31:0] s_query_energy,
    input  logic signed [31:0] s_query_cosine,
    input  logic               s_last,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [47:0] m_weighted_sum,
    output logic [8:0]         m_row_echo,
    output logic               m_saturated
);
    typedef enum logic [3:0] {
        ST_IDLE, ST_WRITE, ST_SRCH_E, ST_SRCH_C, ST_FRAC_E, ST_DIV_E,
        ST_FRAC_C, ST_DIV_C, ST_GRID, ST_MUL, ST_MIX, ST_PROD, ST_ACC
    } state_t;

    // Memories
    logic signed [31:0] grid_mem   [wbti_pkg::ROWS*wbti_pkg::ENERGY_KNOTS*wbti_pkg::COSINE_KNOTS];
    logic signed [31:0] energy_mem [wbti_pkg::ENERGY_KNOTS];
    logic signed [31:0] cosine_mem [wbti_pkg::COSINE_KNOTS];

    state_t state_reg;
    logic [4:0] e_used_reg;
    logic [5:0] c_used_reg;
    logic [1:0] op_reg;
    logic [8:0] row_reg;
    logic [3:0] es_reg;
    logic [4:0] cs_reg;
    logic signed [31:0] wv_reg, qe_reg, qc_reg;
    logic last_reg;

    // search state
    logic [5:0] first_reg, len_reg;
    logic [3:0] ex_reg;
    logic [4:0] cx_reg;
    logic signed [31:0] ax_rd_reg, lo_reg;
    logic [1:0] sub_reg;
    logic [24:0] t_reg, u_reg;

    // arithmetic
    logic signed [66:0] acc_reg;
    logic signed [65:0] mul_res_reg;
    logic signed [32:0] mul_a_reg, mul_b_reg;
    logic signed [31:0] g_rd_reg;
    logic [2:0] k_reg;
    logic signed [47:0] sum_reg;
    logic clip_reg;

    logic div_start, div_done;
    logic [32:0] div_num, div_den;
    logic [23:0] div_q;

    wbti_divider u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .num(div_num), .den(div_den), .done(div_done), .quot(div_q)
    );

    // effective knot counts
    logic [5:0] ne, nc;
    always_comb begin
        ne = {1'b0, e_used_reg};
        if (e_used_reg < 5'd2) ne = 6'd2;
        else if (e_used_reg > 5'd16) ne = 6'd16;
        nc = c_used_reg;
        if (c_used_reg < 6'd2) nc = 6'd2;
        else if (c_used_reg > 6'd32) nc = 6'd32;
    end

    // search probe index, axis value and compare
    logic [5:0] half, probe;
    logic signed [32:0] qv, lo_v, hi_v, num_v, den_v;
    logic [5:0] fsel, nsel;
    always_comb begin
        half  = len_reg >> 1;
        probe = first_reg + half;
        qv    = (state_reg == ST_SRCH_E || state_reg == ST_FRAC_E) ?
                33'(qe_reg) : 33'(qc_reg);
        nsel  = (state_reg == ST_SRCH_E) ? ne : nc;
        fsel  = first_reg;
        if (fsel < 6'd1) fsel = 6'd1;
        if (fsel > nsel - 6'd1) fsel = nsel - 6'd1;
        lo_v  = 33'(lo_reg);
        hi_v  = 33'(ax_rd_reg);
        num_v = qv - lo_v;
        den_v = hi_v - lo_v;
    end

    // grid address of corner k (bit0 energy+1, bit1 cosine+1)
    logic [wbti_pkg::GRID_AW-1:0] g_addr, w_addr;
    always_comb begin
        g_addr = {row_reg, ex_reg - {3'b0, ~k_reg[0]}, cx_reg - {4'b0, ~k_reg[1]}};
        w_addr = {row_reg, es_reg, cs_reg};
    end

    // weights; the low-corner weight is never negative, so 27 bits carry it
    logic signed [32:0] w_k;
    logic signed [26:0] tu;
    always_comb begin
        tu = 27'(mul_res_reg[49:24]) + 27'(mul_res_reg[23]);
        case (k_reg[1:0])
            2'd0: w_k = 33'(27'sd16777216 - 27'(t_reg) - 27'(u_reg) + 27'(lo_reg));
            2'd1: w_k = 33'(t_reg) - 33'(lo_reg);
            2'd2: w_k = 33'(u_reg) - 33'(lo_reg);
            default: w_k = 33'(lo_reg);
        endcase
    end

    logic signed [47:0] prod_v;
    logic signed [48:0] s_v;
    logic signed [31:0] mix_v;
    always_comb begin
        mix_v  = 32'((acc_reg + 67'sd8388608) >>> 24);
        prod_v = 48'((mul_res_reg + 66'sd8388608) >>> 24);
        s_v    = 49'(sum_reg) + 49'(prod_v);
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign div_start = (state_reg == ST_FRAC_E || state_reg == ST_FRAC_C) &&
                       sub_reg == 2'd1 && !(den_v <= 0 || num_v <= 0 || num_v >= den_v);
    assign div_num = num_v;
    assign div_den = den_v;

    // memories
    always_ff @(posedge aclk) begin
        if (state_reg == ST_WRITE) begin
            case (op_reg)
                wbti_pkg::OP_GRID:   grid_mem[w_addr] <= wv_reg;
                wbti_pkg::OP_ENERGY: energy_mem[es_reg] <= wv_reg;
                wbti_pkg::OP_COSINE: cosine_mem[cs_reg] <= wv_reg;
                default: ;
            endcase
        end
        g_rd_reg <= grid_mem[g_addr];
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            e_used_reg <= wbti_pkg::ENERGY_USED_RST;
            c_used_reg <= wbti_pkg::COSINE_USED_RST;
            sum_reg    <= '0;
            clip_reg   <= 1'b0;
            m_valid    <= 1'b0;
            sub_reg    <= '0;
            k_reg      <= '0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    wbti_pkg::CFG_ENERGY_USED: e_used_reg <= cfg_data[4:0];
                    default:                   c_used_reg <= cfg_data;
                endcase
            end
            if (m_valid && m_ready) m_valid <= 1'b0;
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid && s_ready) begin
                        op_reg <= s_op; row_reg <= s_row; es_reg <= s_energy_slot;
                        cs_reg <= s_cosine_slot; wv_reg <= s_write_value;
                        qe_reg <= s_query_energy; qc_reg <= s_query_cosine;
                        last_reg <= s_last;
                        first_reg <= '0; len_reg <= ne; sub_reg <= '0;
                        state_reg <= (s_op == wbti_pkg::OP_QUERY) ? ST_SRCH_E : ST_WRITE;
                    end
                end
                ST_WRITE: state_reg <= ST_IDLE;
                ST_SRCH_E, ST_SRCH_C: begin
                    // sub 0: read probe; sub 1: compare
                    if (len_reg == 6'd0) begin
                        first_reg <= fsel; sub_reg <= '0;
                        state_reg <= (state_reg == ST_SRCH_E) ? ST_FRAC_E : ST_FRAC_C;
                    end else if (sub_reg == 2'd0) begin
                        ax_rd_reg <= (state_reg == ST_SRCH_E) ?
                                     energy_mem[probe[3:0]] : cosine_mem[probe[4:0]];
                        sub_reg <= 2'd1;
                    end else begin
                        sub_reg <= 2'd0;
                        if (33'(ax_rd_reg) <= qv) begin
                            first_reg <= probe + 6'd1;
                            len_reg   <= len_reg - half - 6'd1;
                        end else len_reg <= half;
                    end
                end
                ST_FRAC_E, ST_FRAC_C: begin
                    if (sub_reg == 2'd0) begin
                        if (state_reg == ST_FRAC_E) begin
                            lo_reg <= energy_mem[4'(first_reg - 6'd1)];
                            ax_rd_reg <= energy_mem[first_reg[3:0]];
                            ex_reg <= first_reg[3:0];
                        end else begin
                            lo_reg <= cosine_mem[5'(first_reg - 6'd1)];
                            ax_rd_reg <= cosine_mem[first_reg[4:0]];
                            cx_reg <= first_reg[4:0];
                        end
                        sub_reg <= 2'd1;
                    end else begin
                        sub_reg <= 2'd0;
                        if (div_start)
                            state_reg <= (state_reg == ST_FRAC_E) ? ST_DIV_E : ST_DIV_C;
                        else begin
                            if (state_reg == ST_FRAC_E) begin
                                t_reg <= (den_v <= 0 || num_v <= 0) ? 25'd0 : 25'd16777216;
                                first_reg <= '0; len_reg <= nc; state_reg <= ST_SRCH_C;
                            end else begin
                                u_reg <= (den_v <= 0 || num_v <= 0) ? 25'd0 : 25'd16777216;
                                state_reg <= ST_GRID;
                            end
                        end
                    end
                end
                ST_DIV_E: if (div_done) begin
                    t_reg <= {1'b0, div_q};
                    first_reg <= '0; len_reg <= nc; state_reg <= ST_SRCH_C;
                end
                ST_DIV_C: if (div_done) begin
                    u_reg <= {1'b0, div_q};
                    state_reg <= ST_GRID;
                end
                ST_GRID: begin
                    // t*u through the shared multiplier
                    mul_a_reg <= 33'(t_reg); mul_b_reg <= 33'(u_reg);
                    acc_reg <= '0; k_reg <= 3'd0; sub_reg <= 2'd0;
                    state_reg <= ST_MUL;
                end
                ST_MUL: begin
                    // sub 0: t*u; sub 1: grid read settles (tu kept on corner 0);
                    // sub 2: load weight and word; sub 3: corner product
                    if (sub_reg == 2'd0) begin
                        mul_res_reg <= mul_a_reg * mul_b_reg;
                        sub_reg <= 2'd1;
                    end else if (sub_reg == 2'd1) begin
                        if (k_reg == 3'd0) lo_reg <= 32'(tu);
                        sub_reg <= 2'd2;
                    end else if (sub_reg == 2'd2) begin
                        // grid word ready for corner k
                        if ({1'b0, row_reg} >= 10'(wbti_pkg::ROWS)) mul_b_reg <= '0;
                        else mul_b_reg <= 33'(g_rd_reg);
                        mul_a_reg <= w_k;
                        sub_reg <= 2'd3;
                    end else begin
                        mul_res_reg <= mul_a_reg * mul_b_reg;
                        state_reg <= ST_MIX;
                    end
                end
                ST_MIX: begin
                    acc_reg <= acc_reg + 67'(mul_res_reg);
                    if (k_reg == 3'd3) state_reg <= ST_PROD;
                    else begin
                        k_reg <= k_reg + 3'd1; sub_reg <= 2'd1; state_reg <= ST_MUL;
                    end
                end
                ST_PROD: begin
                    mul_a_reg <= 33'(mix_v); mul_b_reg <= 33'(qc_reg);
                    sub_reg <= 2'd0; state_reg <= ST_ACC;
                end
                ST_ACC: begin
                    if (sub_reg == 2'd0) begin
                        mul_res_reg <= mul_a_reg * mul_b_reg;
                        sub_reg <= 2'd1;
                    end else if (!(last_reg && m_valid)) begin
                        logic signed [47:0] ns;
                        logic nclip;
                        ns = s_v[47:0];
                        nclip = clip_reg;
                        if (s_v > 49'(wbti_pkg::SUM_MAX)) begin
                            ns = wbti_pkg::SUM_MAX; nclip = 1'b1;
                        end
                        if (s_v < 49'(wbti_pkg::SUM_MIN)) begin
                            ns = wbti_pkg::SUM_MIN; nclip = 1'b1;
                        end
                        if (last_reg) begin
                            m_weighted_sum <= ns; m_row_echo <= row_reg;
                            m_saturated <= nclip; m_valid <= 1'b1;
                            sum_reg <= '0; clip_reg <= 1'b0;
                        end else begin
                            sum_reg <= ns; clip_reg <= nclip;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    `WBTI_ASSERT_IMP(a_ready_idle, s_ready, state_reg == ST_IDLE,
        "ready outside idle")
    `WBTI_ASSERT_NEXT(a_hold_out, m_valid && !m_ready, m_valid && $stable(m_weighted_sum),
        "result dropped while stalled")
    `WBTI_ASSERT_IMP(a_frac_range, state_reg == ST_GRID,
        t_reg <= 25'd16777216 && u_reg <= 25'd16777216, "fraction above one")
    `WBTI_ASSERT_NEXT(a_write_short, state_reg == ST_WRITE, state_reg == ST_IDLE,
        "write took more than one cycle")
endmodule
